[rtl/bbc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bbc_pkg: shared types and constants for the balanced bracket counter
// Widths, modulus, Barrett constant, sequencer states and the request and
// response bundles between the sequencer and the modular multiplier.
// ============================================================================
package bbc_pkg;

    // field widths
    localparam int unsigned LEN_W  = 21;                // seq_length
    localparam int unsigned HALF_W = LEN_W - 1;         // m = n / 2
    localparam int unsigned CNT_W  = 30;                // seq_count
    localparam int unsigned S_TDATA_W = ((LEN_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((CNT_W + 7) / 8) * 8;

    // largest accepted length
    localparam logic [31:0] MAX_LENGTH = 32'd1048576;

    // prime modulus and Fermat exponent
    localparam logic [CNT_W-1:0] MOD     = 30'd1000000007;
    localparam logic [CNT_W-1:0] MOD_EXP = MOD - 30'd2;

    // exponent bit index
    localparam int unsigned EXP_IDX_W = $clog2(CNT_W);
    localparam logic [EXP_IDX_W-1:0] EXP_LAST = EXP_IDX_W'(CNT_W - 1);

    // Barrett reduction, k = CNT_W: mu = floor(2^(2k) / MOD)
    localparam int unsigned MU_W  = CNT_W + 1;
    localparam int unsigned MUL_W = CNT_W + 2;          // multiplier operand width
    localparam int unsigned PROD_W = 2 * CNT_W;         // a * b
    localparam int unsigned QT_W  = 2 * CNT_W + 2;      // q1 * mu
    localparam logic [MU_W-1:0] BARRETT_MU =
        MU_W'((64'd1 << (2 * CNT_W)) / 64'(MOD));

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACT,
        ST_DEN_SQ,
        ST_DEN_M1,
        ST_POW_MUL,
        ST_POW_SQ,
        ST_FINAL,
        ST_DONE
    } bbc_state_t;

    // multiplier phases
    typedef enum logic [1:0] {
        MM_IDLE,
        MM_QUOT,
        MM_BACK,
        MM_FIX
    } mm_phase_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] result;
    } mm_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             oor;
    } bbc_res_t;

endpackage

[rtl/bbc_modmul.sv]
`timescale 1ns / 1ps
// ============================================================================
// bbc_modmul: multi-cycle modular multiplier
// a * b mod MOD by Barrett reduction on one shared 32x32 multiplier:
// product, quotient estimate, back-multiply, then a final correction.
// Result and done appear in the MM_FIX phase, after the MM_QUOT and MM_BACK phases.
// ============================================================================
module bbc_modmul (
    input  logic            aclk,
    input  logic            aresetn,
    input  bbc_pkg::mm_req_t req,
    output bbc_pkg::mm_rsp_t rsp
);

    bbc_pkg::mm_phase_t phase_reg, phase_next;

    logic [bbc_pkg::PROD_W-1:0] x_reg;
    logic [bbc_pkg::QT_W-1:0]   t_reg;
    logic [bbc_pkg::MUL_W-1:0]  u_reg;

    logic [bbc_pkg::MUL_W-1:0]   mul_a;
    logic [bbc_pkg::MUL_W-1:0]   mul_b;
    logic [2*bbc_pkg::MUL_W-1:0] prod;

    logic [bbc_pkg::MUL_W-1:0] rem;
    logic [bbc_pkg::MUL_W:0]   rem_m1;
    logic [bbc_pkg::MUL_W:0]   rem_m2;
    logic [bbc_pkg::CNT_W-1:0] fixed;

    // shared multiplier operand select
    always_comb begin
        unique case (phase_reg)
            bbc_pkg::MM_QUOT: begin
                mul_a = bbc_pkg::MUL_W'(x_reg[bbc_pkg::PROD_W-1:bbc_pkg::CNT_W-1]);
                mul_b = bbc_pkg::MUL_W'(bbc_pkg::BARRETT_MU);
            end
            bbc_pkg::MM_BACK: begin
                mul_a = bbc_pkg::MUL_W'(t_reg[bbc_pkg::QT_W-1:bbc_pkg::CNT_W+1]);
                mul_b = bbc_pkg::MUL_W'(bbc_pkg::MOD);
            end
            default: begin
                mul_a = bbc_pkg::MUL_W'(req.a);
                mul_b = bbc_pkg::MUL_W'(req.b);
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // remainder is below 3*MOD: at most two subtractions
    assign rem    = x_reg[bbc_pkg::MUL_W-1:0] - u_reg;
    assign rem_m1 = {1'b0, rem} - (bbc_pkg::MUL_W + 1)'(bbc_pkg::MOD);
    assign rem_m2 = {1'b0, rem} - ((bbc_pkg::MUL_W + 1)'(bbc_pkg::MOD) << 1);

    always_comb begin
        priority if (!rem_m2[bbc_pkg::MUL_W]) begin
            fixed = rem_m2[bbc_pkg::CNT_W-1:0];
        end else if (!rem_m1[bbc_pkg::MUL_W]) begin
            fixed = rem_m1[bbc_pkg::CNT_W-1:0];
        end else begin
            fixed = rem[bbc_pkg::CNT_W-1:0];
        end
    end

    // phase sequencing
    always_comb begin
        unique case (phase_reg)
            bbc_pkg::MM_IDLE: phase_next = req.start ? bbc_pkg::MM_QUOT : bbc_pkg::MM_IDLE;
            bbc_pkg::MM_QUOT: phase_next = bbc_pkg::MM_BACK;
            bbc_pkg::MM_BACK: phase_next = bbc_pkg::MM_FIX;
            default:          phase_next = bbc_pkg::MM_IDLE;
        endcase
    end

    always_comb begin
        rsp.done   = (phase_reg == bbc_pkg::MM_FIX);
        rsp.result = fixed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bbc_pkg::MM_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            bbc_pkg::MM_IDLE: x_reg <= prod[bbc_pkg::PROD_W-1:0];
            bbc_pkg::MM_QUOT: t_reg <= prod[bbc_pkg::QT_W-1:0];
            bbc_pkg::MM_BACK: u_reg <= prod[bbc_pkg::MUL_W-1:0];
            default: ;
        endcase
    end

    // checks
    a_start_when_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> phase_reg == bbc_pkg::MM_IDLE)
        else $error("modmul started while busy");

    a_result_reduced : assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> rsp.result < bbc_pkg::MOD)
        else $error("modmul result not reduced");

    a_done_then_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> phase_reg == bbc_pkg::MM_IDLE)
        else $error("modmul did not return to idle");

endmodule

[rtl/bbc_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// bbc_ctrl: sequencer for the Catalan computation
// Walks factorial, denominator, Fermat inverse and final product, issuing
// one modular multiply at a time to the shared multiplier.
// ============================================================================
module bbc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [bbc_pkg::LEN_W-1:0]   in_length,
    output logic                        in_ready,
    output bbc_pkg::bbc_res_t           res,
    input  logic                        out_ready,
    output bbc_pkg::mm_req_t            mm_req,
    input  bbc_pkg::mm_rsp_t            mm_rsp
);

    bbc_pkg::bbc_state_t state_reg, state_next;

    logic                            issued_reg, issued_next;
    logic [bbc_pkg::LEN_W-1:0]       n_reg, n_next;
    logic [bbc_pkg::LEN_W-1:0]       k_reg, k_next;
    logic [bbc_pkg::HALF_W-1:0]      m_reg, m_next;
    logic [bbc_pkg::CNT_W-1:0]       f_reg, f_next;
    logic [bbc_pkg::CNT_W-1:0]       fm_reg, fm_next;
    logic [bbc_pkg::CNT_W-1:0]       base_reg, base_next;
    logic [bbc_pkg::CNT_W-1:0]       acc_reg, acc_next;
    logic [bbc_pkg::EXP_IDX_W-1:0]   eb_reg, eb_next;
    logic [bbc_pkg::CNT_W-1:0]       res_count_reg, res_count_next;
    logic                            res_oor_reg, res_oor_next;

    logic need_mul;
    logic too_long;

    assign too_long = (32'(in_length) > bbc_pkg::MAX_LENGTH);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    priority if (too_long || in_length[0]) begin
                        state_next = bbc_pkg::ST_DONE;
                    end else if (in_length == '0) begin
                        state_next = bbc_pkg::ST_DEN_SQ;
                    end else begin
                        state_next = bbc_pkg::ST_FACT;
                    end
                end
            end
            bbc_pkg::ST_FACT: begin
                if (mm_rsp.done && k_reg == n_reg) state_next = bbc_pkg::ST_DEN_SQ;
            end
            bbc_pkg::ST_DEN_SQ: begin
                if (mm_rsp.done) state_next = bbc_pkg::ST_DEN_M1;
            end
            bbc_pkg::ST_DEN_M1: begin
                if (mm_rsp.done) state_next = bbc_pkg::ST_POW_MUL;
            end
            bbc_pkg::ST_POW_MUL: begin
                if (!bbc_pkg::MOD_EXP[eb_reg] || mm_rsp.done) state_next = bbc_pkg::ST_POW_SQ;
            end
            bbc_pkg::ST_POW_SQ: begin
                if (mm_rsp.done) begin
                    state_next = (eb_reg == bbc_pkg::EXP_LAST) ? bbc_pkg::ST_FINAL
                                                               : bbc_pkg::ST_POW_MUL;
                end
            end
            bbc_pkg::ST_FINAL: begin
                if (mm_rsp.done) state_next = bbc_pkg::ST_DONE;
            end
            bbc_pkg::ST_DONE: begin
                if (out_ready) state_next = bbc_pkg::ST_IDLE;
            end
            default: state_next = bbc_pkg::ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        in_ready  = (state_reg == bbc_pkg::ST_IDLE);
        res.valid = (state_reg == bbc_pkg::ST_DONE);
        res.count = res_count_reg;
        res.oor   = res_oor_reg;
        need_mul  = 1'b1;
        mm_req.a  = '0;
        mm_req.b  = '0;
        unique case (state_reg)
            bbc_pkg::ST_FACT: begin
                mm_req.a = f_reg;
                mm_req.b = bbc_pkg::CNT_W'(k_reg);
            end
            bbc_pkg::ST_DEN_SQ: begin
                mm_req.a = fm_reg;
                mm_req.b = fm_reg;
            end
            bbc_pkg::ST_DEN_M1: begin
                mm_req.a = base_reg;
                mm_req.b = bbc_pkg::CNT_W'(m_reg) + bbc_pkg::CNT_W'(1);
            end
            bbc_pkg::ST_POW_MUL: begin
                mm_req.a = acc_reg;
                mm_req.b = base_reg;
                need_mul = bbc_pkg::MOD_EXP[eb_reg];
            end
            bbc_pkg::ST_POW_SQ: begin
                mm_req.a = base_reg;
                mm_req.b = base_reg;
            end
            bbc_pkg::ST_FINAL: begin
                mm_req.a = f_reg;
                mm_req.b = acc_reg;
            end
            default: need_mul = 1'b0;
        endcase
        mm_req.start = need_mul && !issued_reg;
    end

    // datapath updates
    always_comb begin
        issued_next    = issued_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        f_next         = f_reg;
        fm_next        = fm_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        eb_next        = eb_reg;
        res_count_next = res_count_reg;
        res_oor_next   = res_oor_reg;

        if (mm_req.start) issued_next = 1'b1;
        if (mm_rsp.done)  issued_next = 1'b0;

        unique case (state_reg)
            bbc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    n_next         = in_length;
                    m_next         = in_length[bbc_pkg::LEN_W-1:1];
                    k_next         = bbc_pkg::LEN_W'(1);
                    f_next         = bbc_pkg::CNT_W'(1);
                    fm_next        = bbc_pkg::CNT_W'(1);
                    res_count_next = '0;
                    res_oor_next   = too_long;
                end
            end
            bbc_pkg::ST_FACT: begin
                if (mm_rsp.done) begin
                    f_next = mm_rsp.result;
                    if (k_reg == bbc_pkg::LEN_W'(m_reg)) fm_next = mm_rsp.result;
                    k_next = k_reg + bbc_pkg::LEN_W'(1);
                end
            end
            bbc_pkg::ST_DEN_SQ: begin
                if (mm_rsp.done) base_next = mm_rsp.result;
            end
            bbc_pkg::ST_DEN_M1: begin
                if (mm_rsp.done) begin
                    base_next = mm_rsp.result;
                    acc_next  = bbc_pkg::CNT_W'(1);
                    eb_next   = '0;
                end
            end
            bbc_pkg::ST_POW_MUL: begin
                if (mm_rsp.done) acc_next = mm_rsp.result;
            end
            bbc_pkg::ST_POW_SQ: begin
                if (mm_rsp.done) begin
                    base_next = mm_rsp.result;
                    eb_next   = eb_reg + bbc_pkg::EXP_IDX_W'(1);
                end
            end
            bbc_pkg::ST_FINAL: begin
                if (mm_rsp.done) begin
                    res_count_next = mm_rsp.result;
                    res_oor_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bbc_pkg::ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        m_reg         <= m_next;
        f_reg         <= f_next;
        fm_reg        <= fm_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        eb_reg        <= eb_next;
        res_count_reg <= res_count_next;
        res_oor_reg   <= res_oor_next;
    end

    // checks
    a_oor_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbc_pkg::ST_DONE && res_oor_reg) |-> res_count_reg == '0)
        else $error("out-of-range result with nonzero count");

    a_done_expected : assert property (@(posedge aclk) disable iff (!aresetn)
        mm_rsp.done |-> issued_reg)
        else $error("multiplier result with no request outstanding");

    a_idle_no_mul : assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !issued_reg)
        else $error("multiply outstanding while ready for input");

endmodule

[rtl/balanced_bracket_count_mod_prime.sv]
`timescale 1ns / 1ps
// ============================================================================
// balanced_bracket_count_mod_prime: Catalan number modulo 1000000007
// Counts balanced bracket sequences of length n: 0 for odd n, otherwise
// (2m)! / (m! * m! * (m+1)) mod p with m = n/2, inverse by Fermat.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: seq_length [20:0]
//  m_      | out | m_tvalid/m_tready  | m_tdata: seq_count [29:0]; m_tuser: out_of_range
//
//  Flow: one item at a time; an even length n takes n + 48 modular multiplies
//    (factorial, denominator, 45 for the inverse, final product), each on the
//    single shared 32x32 multiplier.
//    Odd and out-of-range lengths skip the multiplies and go straight to the result.
//  Reset: aresetn synchronous, active low; clears sequencer and output valid.
//  Stalls: a stalled result waits in the output register, a second one in the sequencer.
//
module balanced_bracket_count_mod_prime (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bbc_pkg::S_TDATA_W-1:0]   s_tdata,   // [20:0] seq_length
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bbc_pkg::M_TDATA_W-1:0]   m_tdata,   // [29:0] seq_count
    output logic                            m_tuser    // [0] out_of_range
);

    bbc_pkg::bbc_res_t res;
    bbc_pkg::mm_req_t  mm_req;
    bbc_pkg::mm_rsp_t  mm_rsp;

    logic                      out_ready;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [bbc_pkg::CNT_W-1:0] m_count_reg, m_count_next;
    logic                      m_oor_reg, m_oor_next;

    // sequencer: factorial, denominator, inverse, final product
    bbc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_length (s_tdata[bbc_pkg::LEN_W-1:0]),
        .in_ready  (s_tready),
        .res       (res),
        .out_ready (out_ready),
        .mm_req    (mm_req),
        .mm_rsp    (mm_rsp)
    );

    // shared modular multiplier
    bbc_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // output register: loads when empty or being drained this cycle
    assign out_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_count_next  = m_count_reg;
        m_oor_next    = m_oor_reg;
        if (out_ready) begin
            m_tvalid_next = res.valid;
            if (res.valid) begin
                m_count_next = res.count;
                m_oor_next   = res.oor;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_count_reg <= m_count_next;
        m_oor_reg   <= m_oor_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = bbc_pkg::M_TDATA_W'(m_count_reg);
    assign m_tuser  = m_oor_reg;

endmodule
